FILE: rtl/cbid_pkg.sv
// Shared types and constants for the character buffer insert/delete block.
// No dependencies; used by rtl/char_buffer_insert_delete_block.sv.

package cbid_pkg;

   // Buffer geometry
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   localparam int CHAR_W   = 8;
   localparam int CMD_W    = 3;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OVERWRITE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOVE,
      ST_DRAIN,
      ST_PUTCH,
      ST_RDWAIT,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/cbid_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.

module cbid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/char_buffer_insert_delete_block.sv
// Top level of the character buffer with append, insert, block delete,
// overwrite and read. Depends on rtl/cbid_pkg.sv and rtl/cbid_ram.sv.
//
// Usage:
//   A request enters on req_* when req_valid is high and req_stall is low.
//   Each request gives exactly one response on rsp_*, taken when rsp_valid
//   is high and rsp_stall is low: the character read (0 unless an accepted
//   read), the character count after the command, and the accepted flag.
//   The block takes one request at a time; req_stall is high from the
//   accepting edge until the response is loaded into the output register.
//   Append, overwrite, rejected and unknown commands go from idle straight
//   to the finish state; read passes through the read-wait state. Insert
//   moves the tail up one entry a cycle, then writes the new character;
//   block delete moves the tail down. The rate is set by the single read
//   and single write port of the character RAM, one entry moved per
//   cycle.
//   A waiting response does not block the next request; a stalled
//   receiver holds the response steady and only delays the following one.
//   Reset (synchronous, active high) empties the buffer and drops any
//   pending response; RAM contents are left as they are.

module char_buffer_insert_delete_block
   import cbid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [ADDR_W-1:0] req_position,
   input  logic [ADDR_W-1:0] req_end_position,
   input  logic [CHAR_W-1:0] req_char_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_read_char,
   output logic [FILL_W-1:0] rsp_used_count,
   output logic              rsp_accepted
);

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic              up_ff, up_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              ok_ff, ok_in;
   logic [CHAR_W-1:0] rdchar_ff, rdchar_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_read_char_ff, rsp_read_char_in;
   logic [FILL_W-1:0] rsp_used_count_ff, rsp_used_count_in;
   logic              rsp_accepted_ff, rsp_accepted_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CHAR_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CHAR_W-1:0] ram_rd_data;

   logic [FILL_W-1:0] pos_ext;
   logic [FILL_W-1:0] end_ext;
   logic [FILL_W-1:0] span;
   logic              not_full;
   logic              pos_in_range;
   logic              ins_ok;
   logic              del_ok;
   logic              out_free;

   cbid_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Bounds checks on the incoming request
   assign pos_ext      = {1'b0, req_position};
   assign end_ext      = {1'b0, req_end_position};
   assign span         = end_ext - pos_ext + FILL_W'(1);
   assign not_full     = fill_ff < FILL_W'(CAPACITY);
   assign pos_in_range = pos_ext < fill_ff;
   assign ins_ok       = not_full && (pos_ext <= fill_ff);
   assign del_ok       = (req_position <= req_end_position) && (end_ext < fill_ff);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff            <= pos_in;
      ch_ff             <= ch_in;
      src_ff            <= src_in;
      dst_ff            <= dst_in;
      last_ff           <= last_in;
      up_ff             <= up_in;
      wr_addr_ff        <= wr_addr_in;
      ok_ff             <= ok_in;
      rdchar_ff         <= rdchar_in;
      rsp_read_char_ff  <= rsp_read_char_in;
      rsp_used_count_ff <= rsp_used_count_in;
      rsp_accepted_ff   <= rsp_accepted_in;
   end

   // Sequencer: next state, RAM port control and response loading
   always_comb begin
      state_in          = state_ff;
      fill_in           = fill_ff;
      pos_in            = pos_ff;
      ch_in             = ch_ff;
      src_in            = src_ff;
      dst_in            = dst_ff;
      last_in           = last_ff;
      up_in             = up_ff;
      wr_pend_in        = wr_pend_ff;
      wr_addr_in        = wr_addr_ff;
      ok_in             = ok_ff;
      rdchar_in         = rdchar_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_read_char_in  = rsp_read_char_ff;
      rsp_used_count_in = rsp_used_count_ff;
      rsp_accepted_in   = rsp_accepted_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = wr_addr_ff;
      ram_wr_data       = ram_rd_data;
      ram_rd_addr       = src_ff;

      case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = req_position;
            if (req_valid) begin
               pos_in     = req_position;
               ch_in      = req_char_value;
               rdchar_in  = '0;
               ok_in      = 1'b0;
               wr_pend_in = 1'b0;
               state_in   = ST_FINISH;
               case (req_command)
                  CMD_APPEND: begin
                     if (not_full) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = fill_ff[ADDR_W-1:0];
                        ram_wr_data = req_char_value;
                        fill_in     = fill_ff + FILL_W'(1);
                        ok_in       = 1'b1;
                     end
                  end
                  CMD_INSERT: begin
                     if (ins_ok) begin
                        fill_in = fill_ff + FILL_W'(1);
                        ok_in   = 1'b1;
                        if (pos_in_range) begin
                           // Tail moves up, last entry first
                           src_in   = fill_ff[ADDR_W-1:0] - ADDR_W'(1);
                           dst_in   = fill_ff[ADDR_W-1:0];
                           last_in  = req_position;
                           up_in    = 1'b0;
                           state_in = ST_MOVE;
                        end else begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = req_position;
                           ram_wr_data = req_char_value;
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (del_ok) begin
                        fill_in = fill_ff - span;
                        ok_in   = 1'b1;
                        if ((end_ext + FILL_W'(1)) < fill_ff) begin
                           // Tail moves down, first entry first
                           src_in   = req_end_position + ADDR_W'(1);
                           dst_in   = req_position;
                           last_in  = ADDR_W'(fill_ff - FILL_W'(1));
                           up_in    = 1'b1;
                           state_in = ST_MOVE;
                        end
                     end
                  end
                  CMD_OVERWRITE: begin
                     if (pos_in_range) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = req_position;
                        ram_wr_data = req_char_value;
                        ok_in       = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if (pos_in_range) begin
                        ok_in    = 1'b1;
                        state_in = ST_RDWAIT;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_MOVE: begin
            // Read the next source while writing the previous one
            ram_wr_en  = wr_pend_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = dst_ff;
            if (src_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else if (up_ff) begin
               src_in = src_ff + ADDR_W'(1);
               dst_in = dst_ff + ADDR_W'(1);
            end else begin
               src_in = src_ff - ADDR_W'(1);
               dst_in = dst_ff - ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            ram_wr_en  = 1'b1;
            wr_pend_in = 1'b0;
            state_in   = up_ff ? ST_FINISH : ST_PUTCH;
         end
         ST_PUTCH: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = ch_ff;
            state_in    = ST_FINISH;
         end
         ST_RDWAIT: begin
            rdchar_in = ram_rd_data;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_read_char_in  = rdchar_ff;
               rsp_used_count_in = fill_ff;
               rsp_accepted_in   = ok_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_char  = rsp_read_char_ff;
   assign rsp_used_count = rsp_used_count_ff;
   assign rsp_accepted   = rsp_accepted_ff;

endmodule
